// File: rtl/bra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants
// Store geometry, operation codes and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int unsigned STORE_BYTES = 8192;
	localparam int unsigned STORE_BITS  = STORE_BYTES * 8;
	localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_GET   = 2'd1,
		OP_SET   = 2'd2,
		OP_ANY   = 2'd3
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // latch a request and work out its byte span
		logic step;     // advance the byte address
		logic wr_zero;  // write zero at the byte address
		logic scan_rd;  // read a byte for a range scan
		logic set_rd;   // read the byte to be modified
		logic set_wr;   // write back the modified byte
		logic out_load; // capture the accumulated answer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_last;  // byte address has reached the last byte of the span
		logic empty;    // range holds no bit of the store
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/bra_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_req_if / bra_rsp_if: request and response channels
// Valid/ready channels; a transfer takes place when both are high.
// ----------------------------------------------------------------------------
interface bra_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] bit_index;
	logic [16:0] range_end;
	logic        new_value;

	modport source (output valid, output mode, output bit_index, output range_end,
		output new_value, input ready);
	modport sink (input valid, input mode, input bit_index, input range_end,
		input new_value, output ready);
endinterface

interface bra_rsp_if;
	logic valid;
	logic ready;
	logic answer;

	modport source (output valid, output answer, input ready);
	modport sink (input valid, input answer, output ready);
endinterface
`default_nettype wire

// File: rtl/bitset_range_any_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Get and any walk the bytes the range touches (one for get), then answer; an
//   empty range answers without a walk.
// Throughput: one request at a time; clear walks from byte zero to its last byte,
//   set reads its byte and writes it back. The single memory port, one byte a cycle, sets the walk length.
// Reset: the store is zeroed by a pass over all 8192 bytes, during which no
//   request is taken.
// ----------------------------------------------------------------------------
// bitset_range_any_unit: bit array with clear, get, set and range-any query
// A byte-wide store with a sequencer and a byte-walking datapath.
// ----------------------------------------------------------------------------
module bitset_range_any_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	bra_req_if.sink   req,
	bra_rsp_if.source rsp
);

	bra_pkg::cmd_t cmd;
	bra_pkg::sts_t sts;

	// Sequencer: owns request ready and response valid.
	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: latches the request on load, walks the store, holds the answer
	// register that parts the response from the request side.
	bra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (req.mode),
		.bit_index (req.bit_index),
		.range_end (req.range_end),
		.new_value (req.new_value),
		.cmd       (cmd),
		.sts       (sts),
		.answer    (rsp.answer)
	);

	// Hold off further requests once one is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in progress");

	// Never overwrite an answer that has not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("pending answer overwritten");

	// Stop walking once the last byte of the span is reached.
	a_walk_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.at_last) |=> !cmd.step)
		else $error("byte walk ran past the end of its span");

endmodule
`default_nettype wire

// File: rtl/bra_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_datapath: byte store, address walker and answer accumulator
// Holds the store memory, the span of the current request, the edge masks
// for range scans and the registered answer.
// ----------------------------------------------------------------------------
module bra_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    mode,
	input  wire logic [15:0]   bit_index,
	input  wire logic [16:0]   range_end,
	input  wire logic          new_value,
	input  wire bra_pkg::cmd_t cmd,
	output bra_pkg::sts_t      sts,
	output logic               answer
);

	logic [7:0] store_mem [bra_pkg::STORE_BYTES];

	bra_pkg::addr_t addr_q;
	bra_pkg::addr_t last_q;
	bra_pkg::addr_t first_q;
	logic           empty_q;
	logic           in_range_q;
	logic [7:0]     fmask_q;
	logic [7:0]     lmask_q;
	logic [2:0]     bitpos_q;
	logic           nv_q;
	logic           acc_q;
	logic           answer_q;

	logic [7:0]     rdata_s1;
	logic [7:0]     mask_s1;
	logic           rd_vld_s1;

	logic [31:0]    lo;
	logic [31:0]    hi_raw;
	logic [31:0]    hi;
	logic [31:0]    hm1;
	logic [31:0]    idx_byte;
	logic [31:0]    clr_last;
	logic [7:0]     scan_mask;
	logic [7:0]     bit_mask;
	logic [7:0]     set_byte;
	bra_pkg::op_t   op;

	// span of the incoming request
	always_comb begin
		op       = bra_pkg::op_t'(mode);
		lo       = 32'(bit_index);
		idx_byte = lo >> 3;
		hi_raw   = (op == bra_pkg::OP_GET) ? lo + 32'd1 : 32'(range_end);
		hi       = (hi_raw > 32'(bra_pkg::STORE_BITS)) ? 32'(bra_pkg::STORE_BITS) : hi_raw;
		hm1      = hi - 32'd1;
		clr_last = (idx_byte >= 32'(bra_pkg::STORE_BYTES)) ?
			32'(bra_pkg::STORE_BYTES - 1) : idx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			last_q <= bra_pkg::addr_t'(bra_pkg::STORE_BYTES - 1);
		end else if (cmd.load) begin
			case (op)
				bra_pkg::OP_CLEAR: begin
					addr_q <= '0;
					last_q <= bra_pkg::ADDR_W'(clr_last);
				end
				bra_pkg::OP_SET: begin
					addr_q <= bra_pkg::ADDR_W'(idx_byte);
					last_q <= bra_pkg::ADDR_W'(idx_byte);
				end
				default: begin
					addr_q <= bra_pkg::ADDR_W'(lo >> 3);
					last_q <= bra_pkg::ADDR_W'(hm1 >> 3);
				end
			endcase
		end else if (cmd.step) begin
			addr_q <= addr_q + bra_pkg::addr_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q    <= bra_pkg::ADDR_W'(lo >> 3);
			empty_q    <= (hi <= lo);
			in_range_q <= (idx_byte < 32'(bra_pkg::STORE_BYTES));
			fmask_q    <= 8'hFF << lo[2:0];
			lmask_q    <= 8'hFF >> (3'd7 - hm1[2:0]);
			bitpos_q   <= bit_index[2:0];
			nv_q       <= new_value;
		end
	end

	assign sts.at_last = (addr_q == last_q);
	assign sts.empty   = empty_q;

	// keep only the bits of the range in the partial end bytes
	always_comb begin
		scan_mask = ((addr_q == first_q) ? fmask_q : 8'hFF) &
			(sts.at_last ? lmask_q : 8'hFF);
		bit_mask  = 8'h01 << bitpos_q;
		set_byte  = nv_q ? (rdata_s1 | bit_mask) : (rdata_s1 & ~bit_mask);
	end

	// store memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_zero) begin
			store_mem[addr_q] <= 8'h00;
		end else if (cmd.set_wr && in_range_q) begin
			store_mem[addr_q] <= set_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.set_rd) begin
			rdata_s1 <= store_mem[addr_q];
		end
		mask_s1 <= scan_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
		end
	end

	// accumulate any set bit seen by the scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= 1'b0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q | (|(rdata_s1 & mask_s1));
		end
		if (cmd.out_load) begin
			answer_q <= acc_q;
		end
	end

	assign answer = answer_q;

endmodule
`default_nettype wire

// File: rtl/bra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ctrl: request sequencer
// Walks the clearing pass, the set read-modify-write and the range scan, and
// owns the response valid.
// ----------------------------------------------------------------------------
module bra_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_mode,
	output logic               req_ready,
	input  wire logic          rsp_ready,
	output logic               rsp_valid,
	input  wire bra_pkg::sts_t sts,
	output bra_pkg::cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SET_RD = 7'b0000100,
		S_SET_WR = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_DRAIN  = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   req_fire;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_zero = 1'b1;
				cmd.step    = 1'b1;
				if (sts.at_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					cmd.load = 1'b1;
					case (bra_pkg::op_t'(req_mode))
						bra_pkg::OP_CLEAR: state_d = S_CLEAR;
						bra_pkg::OP_SET:   state_d = S_SET_RD;
						default:           state_d = S_SCAN;
					endcase
				end
			end
			S_SET_RD: begin
				cmd.set_rd = 1'b1;
				state_d    = S_SET_WR;
			end
			S_SET_WR: begin
				cmd.set_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_SCAN: begin
				if (sts.empty) begin
					state_d = S_RESP;
				end else begin
					cmd.scan_rd = 1'b1;
					cmd.step    = 1'b1;
					if (sts.at_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire
